// File: hdl/tcld_pkg.sv
// Shared types, codes and keyword tables for the text command line decoder.
package tcld_pkg;

    // Default sizing of the decoder.
    localparam int DEF_LAMP_COUNT = 32;
    localparam int DEF_LINE_LIMIT = 127;

    // Decoded command codes.
    typedef enum logic [3:0] {
        KIND_UNKNOWN  = 4'd0,
        KIND_SET_BITS = 4'd1,
        KIND_CLR_BITS = 4'd2,
        KIND_ON       = 4'd3,
        KIND_OFF      = 4'd4,
        KIND_ALL_ON   = 4'd5,
        KIND_ALL_OFF  = 4'd6,
        KIND_STATUS   = 4'd7,
        KIND_HELP     = 4'd8
    } cmd_kind_t;

    // Parse phases of one line.
    typedef enum logic [6:0] {
        PH_KEY    = 7'b0000001,
        PH_SPACE  = 7'b0000010,
        PH_SIGNED = 7'b0000100,
        PH_ZERO   = 7'b0001000,
        PH_DIGITS = 7'b0010000,
        PH_TAIL   = 7'b0100000,
        PH_FAIL   = 7'b1000000
    } phase_t;

    // Per-line parse state, apart from the byte position.
    typedef struct packed {
        logic [7:0]  cand;
        phase_t      phase;
        logic [31:0] value;
        logic        neg;
        logic        digit;
        logic        ovf;
        logic        stopped;
    } line_state_t;

    // One decoded command.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] mask;
        logic [5:0]  index;
    } result_t;

    localparam line_state_t LINE_RESET = '{
        cand:    8'hFF,
        phase:   PH_KEY,
        value:   32'd0,
        neg:     1'b0,
        digit:   1'b0,
        ovf:     1'b0,
        stopped: 1'b0
    };

    // Character codes used by the parser.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // Keyword text, padded with NUL, in command code order.
    localparam logic [7:0] KW_TEXT [8][8] = '{
        '{"M", "A", "S", "K", "_", "S", "E", "T"},
        '{"M", "A", "S", "K", "_", "C", "L", "R"},
        '{"O", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"A", "L", "L", "_", "O", "N", 8'h00, 8'h00},
        '{"A", "L", "L", "_", "O", "F", "F", 8'h00},
        '{"S", "T", "A", "T", "U", "S", 8'h00, 8'h00},
        '{"H", "E", "L", "P", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [8] = '{
        4'd8, 4'd8, 4'd2, 4'd3, 4'd6, 4'd7, 4'd6, 4'd4
    };

endpackage

// File: hdl/tcld_step.sv
// Per-byte next-state logic and command decode of the text command line decoder.
module tcld_step
    import tcld_pkg::*;
#(
    parameter int LAMP_COUNT = DEF_LAMP_COUNT,
    parameter int LINE_LIMIT = DEF_LINE_LIMIT,
    localparam int POS_W = $clog2(LINE_LIMIT + 1)
) (
    input  line_state_t      cur,
    input  logic [POS_W-1:0] cur_pos,
    input  logic [7:0]       ch,
    output line_state_t      nxt,
    output logic [POS_W-1:0] nxt_pos,
    output result_t          res
);

    logic        take;
    logic        stop_byte;
    logic        is_ws;
    logic        hex;
    logic        dec_ok;
    logic        lc_ok;
    logic        uc_ok;
    logic        dvalid;
    logic [3:0]  dval;
    logic [31:0] acc_value;
    logic        acc_ovf;
    logic [7:0]  kw_hit;
    logic [7:0]  kw_cand;
    logic [3:0]  kw_done;
    logic [7:0]  kw_single;

    // Byte classification.
    assign take      = !cur.stopped && (cur_pos < POS_W'(LINE_LIMIT));
    assign stop_byte = (ch == CH_NUL) || (ch == CH_CR) || (ch == CH_LF);
    assign is_ws     = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT) || (ch == CH_FF);
    assign hex       = cur.cand[0] || cur.cand[1];
    assign dec_ok    = (ch >= "0") && (ch <= "9");
    assign lc_ok     = (ch >= "a") && (ch <= "f");
    assign uc_ok     = (ch >= "A") && (ch <= "F");
    assign dvalid    = dec_ok || (hex && (lc_ok || uc_ok));

    always_comb begin
        if (dec_ok) begin
            dval = 4'(ch - "0");
        end else if (lc_ok) begin
            dval = 4'(ch - "a" + 8'd10);
        end else begin
            dval = 4'(ch - "A" + 8'd10);
        end
    end

    // Accumulate one digit; a value above 28 bits can take no further digit.
    always_comb begin
        acc_value = cur.value;
        acc_ovf   = cur.ovf;
        if (!cur.ovf) begin
            if (cur.value > 32'h0FFF_FFFF) begin
                acc_ovf = 1'b1;
            end else if (hex) begin
                acc_value = {cur.value[27:0], dval};
            end else begin
                acc_value = (cur.value << 3) + (cur.value << 1) + 32'(dval);
            end
        end
    end

    // Keyword match at the current byte position.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            kw_hit[k] = (cur_pos < POS_W'(KW_LEN[k])) && (KW_TEXT[k][cur_pos[2:0]] == ch);
        end
        kw_cand = cur.cand & kw_hit;
        for (int k = 0; k < 4; k++) begin
            kw_done[k] = kw_cand[k] && (cur_pos == POS_W'(KW_LEN[k] - 4'd1));
        end
        // Lowest completed number keyword wins.
        kw_single = 8'd0;
        for (int k = 3; k >= 0; k--) begin
            if (kw_done[k]) begin
                kw_single = 8'(1 << k);
            end
        end
    end

    // Next line state for the byte.
    always_comb begin
        nxt     = cur;
        nxt_pos = cur_pos;
        if (take) begin
            if (stop_byte) begin
                nxt.stopped = 1'b1;
            end else begin
                nxt_pos = cur_pos + 1'b1;
                unique case (cur.phase)
                    PH_KEY: begin
                        if (kw_cand == 8'd0) begin
                            nxt.cand  = kw_cand;
                            nxt.phase = PH_FAIL;
                        end else if (kw_done != 4'd0) begin
                            nxt.cand  = kw_single;
                            nxt.phase = PH_SPACE;
                        end else begin
                            nxt.cand = kw_cand;
                        end
                    end
                    PH_SPACE, PH_SIGNED: begin
                        if ((cur.phase == PH_SPACE) && is_ws) begin
                            nxt.phase = PH_SPACE;
                        end else if ((cur.phase == PH_SPACE) && (ch == CH_PLUS)) begin
                            nxt.phase = PH_SIGNED;
                        end else if ((cur.phase == PH_SPACE) && (ch == CH_MINUS)) begin
                            nxt.neg   = 1'b1;
                            nxt.phase = PH_SIGNED;
                        end else if (dvalid) begin
                            nxt.digit = 1'b1;
                            nxt.value = acc_value;
                            nxt.ovf   = acc_ovf;
                            nxt.phase = (hex && (ch == "0")) ? PH_ZERO : PH_DIGITS;
                        end else begin
                            nxt.phase = PH_FAIL;
                        end
                    end
                    PH_ZERO: begin
                        if ((ch == "x") || (ch == "X")) begin
                            nxt.phase = PH_DIGITS;
                        end else if (dvalid) begin
                            nxt.digit = 1'b1;
                            nxt.value = acc_value;
                            nxt.ovf   = acc_ovf;
                            nxt.phase = PH_DIGITS;
                        end else begin
                            nxt.phase = PH_TAIL;
                        end
                    end
                    PH_DIGITS: begin
                        if (dvalid) begin
                            nxt.digit = 1'b1;
                            nxt.value = acc_value;
                            nxt.ovf   = acc_ovf;
                        end else begin
                            nxt.phase = PH_TAIL;
                        end
                    end
                    default: begin
                        nxt.phase = cur.phase;
                    end
                endcase
            end
        end
    end

    // Command decode from the state after the byte.
    always_comb begin
        res.kind  = KIND_UNKNOWN;
        res.mask  = 32'd0;
        res.index = 6'd0;
        if (nxt.phase == PH_KEY) begin
            for (int k = 4; k < 8; k++) begin
                if (nxt.cand[k] && (nxt_pos == POS_W'(KW_LEN[k]))) begin
                    res.kind = cmd_kind_t'(4'(k + 1));
                end
            end
        end else if (((nxt.phase == PH_ZERO) || (nxt.phase == PH_DIGITS) ||
                      (nxt.phase == PH_TAIL)) && nxt.digit) begin
            if (nxt.cand[1:0] != 2'b00) begin
                res.kind = nxt.cand[0] ? KIND_SET_BITS : KIND_CLR_BITS;
                if (nxt.ovf) begin
                    res.mask = 32'hFFFF_FFFF;
                end else if (nxt.neg) begin
                    res.mask = 32'd0 - nxt.value;
                end else begin
                    res.mask = nxt.value;
                end
            end else if (!nxt.neg && !nxt.ovf && (nxt.value != 32'd0) &&
                         (nxt.value <= 32'(LAMP_COUNT))) begin
                res.kind  = nxt.cand[2] ? KIND_ON : KIND_OFF;
                res.index = nxt.value[5:0];
            end
        end
    end

endmodule

// File: hdl/text_command_line_decoder.sv
// Top level of the text command line decoder: line state, result register and handshake.
// Throughput: one byte per cycle; a byte is taken whenever the result register is free.
// The command appears on m_valid in the cycle after the line's last byte is taken.
// The per-byte keyword match and digit accumulation fit between the state and result registers.
// Reset (aresetn low, synchronous) clears the line state and empties the result register.
module text_command_line_decoder
    import tcld_pkg::*;
#(
    parameter int LAMP_COUNT = DEF_LAMP_COUNT,
    parameter int LINE_LIMIT = DEF_LINE_LIMIT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_line_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_cmd_kind,
    output logic [31:0] m_lamp_mask,
    output logic [5:0]  m_lamp_index
);

    localparam int POS_W = $clog2(LINE_LIMIT + 1);

    line_state_t      state_reg;
    line_state_t      state_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    result_t          res;
    logic             m_valid_reg;
    result_t          result_reg;
    logic             s_xfer;

    // Next-state and decode logic for the incoming byte.
    tcld_step #(
        .LAMP_COUNT(LAMP_COUNT),
        .LINE_LIMIT(LINE_LIMIT)
    ) u_step (
        .cur    (state_reg),
        .cur_pos(pos_reg),
        .ch     (s_ch),
        .nxt    (state_next),
        .nxt_pos(pos_next),
        .res    (res)
    );

    // A byte may enter whenever the result register is empty or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    // Line state; the line's last byte returns it to the start of a line.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LINE_RESET;
            pos_reg   <= '0;
        end else if (s_xfer) begin
            if (s_line_end) begin
                state_reg <= LINE_RESET;
                pos_reg   <= '0;
            end else begin
                state_reg <= state_next;
                pos_reg   <= pos_next;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer && s_line_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded on the line's last byte.
    always_ff @(posedge aclk) begin
        if (s_xfer && s_line_end) begin
            result_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cmd_kind   = result_reg.kind;
    assign m_lamp_mask  = result_reg.mask;
    assign m_lamp_index = result_reg.index;

endmodule

// File: hdl/tcld_checker.sv
// Port-level assertions for the text command line decoder and their bind.
module tcld_checker
    import tcld_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_line_end,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_cmd_kind,
    input logic [31:0] m_lamp_mask,
    input logic [5:0]  m_lamp_index
);

    // A result held back by the sink stays with its payload unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cmd_kind) &&
            $stable(m_lamp_mask) && $stable(m_lamp_index))
        else $error("result changed while stalled");

    // A new result only follows a transfer that carried the line's last byte.
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_line_end))
        else $error("result without a line end");

    // The input side is open whenever the result register is free.
    a_in_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input blocked with a free result register");

    // Mask and lamp number are zero unless the command carries them.
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cmd_kind <= KIND_HELP) &&
            ((m_cmd_kind == KIND_SET_BITS) || (m_cmd_kind == KIND_CLR_BITS) ||
             (m_lamp_mask == 32'd0)) &&
            ((m_cmd_kind == KIND_ON) || (m_cmd_kind == KIND_OFF) ||
             (m_lamp_index == 6'd0)))
        else $error("result fields inconsistent with command");

endmodule

bind text_command_line_decoder tcld_checker u_tcld_checker (.*);
